// ----- hw/rtl/sbp_pkg.sv -----
// Shared types and constants for the sphere/box push-out pipeline.
// Used by every module under hw/rtl; depends on nothing else.
package sbp_pkg;

    localparam int THRESH_W = 17;
    localparam int EPS_W = 32;
    localparam int CFG_IDX_W = 8;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS = 31;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 17'd45875;
    localparam logic [EPS_W-1:0] EPS_RESET = 32'd42950;

    localparam logic [CFG_IDX_W-1:0] REG_LANDING = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EPSILON = 8'd1;

    // Data carried alongside the square-root pipeline.
    typedef struct packed {
        logic               contact;
        logic [30:0]        ax;
        logic               sx;
        logic signed [31:0] dy;
        logic [30:0]        az;
        logic               sz;
        logic [30:0]        r;
    } sq_side_t;

    // Data carried alongside the divider pipeline.
    typedef struct packed {
        logic        contact;
        logic        landed;
        logic [30:0] pen;
        logic        sx;
        logic        sz;
    } dv_side_t;

endpackage

// ----- hw/rtl/sbp_front.sv -----
// Clamp, offset, squares and contact test: five register stages.
// Depends on sbp_pkg.
module sbp_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic signed [31:0]           cx,
    input  logic signed [31:0]           cy,
    input  logic signed [31:0]           cz,
    input  logic [30:0]                  radius,
    input  logic signed [31:0]           lox,
    input  logic signed [31:0]           loy,
    input  logic signed [31:0]           loz,
    input  logic signed [31:0]           hix,
    input  logic signed [31:0]           hiy,
    input  logic signed [31:0]           hiz,
    input  logic [sbp_pkg::EPS_W-1:0]    eps,
    output logic                         out_valid,
    output logic [63:0]                  dsq,
    output sbp_pkg::sq_side_t            side
);
    import sbp_pkg::*;

    function automatic logic signed [32:0] offset(input logic signed [31:0] c,
                                                  input logic signed [31:0] lo,
                                                  input logic signed [31:0] hi);
        logic signed [31:0] t;
        logic signed [31:0] cl;
        t = (c < hi) ? c : hi;
        cl = (t > lo) ? t : lo;
        return {c[31], c} - {cl[31], cl};
    endfunction

    function automatic logic [32:0] mag(input logic signed [32:0] d);
        return d[32] ? 33'(-d) : 33'(d);
    endfunction

    logic [4:0] v_reg;

    // Stage 1: offsets from the clamped point.
    logic signed [32:0] d1x_reg, d1y_reg, d1z_reg;
    logic [30:0]        r1_reg;
    // Stage 2: magnitudes and the far-axis check.
    logic [30:0]        a2x_reg, a2y_reg, a2z_reg, r2_reg;
    logic               s2x_reg, s2z_reg, far2_reg;
    logic signed [31:0] d2y_reg;
    // Stage 3: squares.
    logic [61:0]        q3x_reg, q3y_reg, q3z_reg, rsq3_reg;
    logic               far3_reg;
    logic [30:0]        a3x_reg, a3z_reg, r3_reg;
    logic               s3x_reg, s3z_reg;
    logic signed [31:0] d3y_reg;
    // Stage 4: sum.
    logic [63:0]        dsq4_reg;
    logic [61:0]        rsq4_reg;
    logic               far4_reg;
    logic [30:0]        a4x_reg, a4z_reg, r4_reg;
    logic               s4x_reg, s4z_reg;
    logic signed [31:0] d4y_reg;
    // Stage 5: contact test.
    logic [63:0]        dsq5_reg;
    sq_side_t           side5_reg;

    logic [32:0] ax_next, ay_next, az_next;

    assign ax_next = mag(d1x_reg);
    assign ay_next = mag(d1y_reg);
    assign az_next = mag(d1z_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d1x_reg <= offset(cx, lox, hix);
            d1y_reg <= offset(cy, loy, hiy);
            d1z_reg <= offset(cz, loz, hiz);
            r1_reg <= radius;

            a2x_reg <= ax_next[30:0];
            a2y_reg <= ay_next[30:0];
            a2z_reg <= az_next[30:0];
            s2x_reg <= d1x_reg[32];
            s2z_reg <= d1z_reg[32];
            d2y_reg <= d1y_reg[31:0];
            r2_reg <= r1_reg;
            far2_reg <= (ax_next >= {2'b00, r1_reg}) || (ay_next >= {2'b00, r1_reg})
                        || (az_next >= {2'b00, r1_reg});

            q3x_reg <= a2x_reg * a2x_reg;
            q3y_reg <= a2y_reg * a2y_reg;
            q3z_reg <= a2z_reg * a2z_reg;
            rsq3_reg <= r2_reg * r2_reg;
            far3_reg <= far2_reg;
            a3x_reg <= a2x_reg;
            a3z_reg <= a2z_reg;
            s3x_reg <= s2x_reg;
            s3z_reg <= s2z_reg;
            d3y_reg <= d2y_reg;
            r3_reg <= r2_reg;

            dsq4_reg <= {2'b00, q3x_reg} + {2'b00, q3y_reg} + {2'b00, q3z_reg};
            rsq4_reg <= rsq3_reg;
            far4_reg <= far3_reg;
            a4x_reg <= a3x_reg;
            a4z_reg <= a3z_reg;
            s4x_reg <= s3x_reg;
            s4z_reg <= s3z_reg;
            d4y_reg <= d3y_reg;
            r4_reg <= r3_reg;

            dsq5_reg <= dsq4_reg;
            side5_reg.contact <= !far4_reg && (dsq4_reg < {2'b00, rsq4_reg})
                                 && (dsq4_reg >= {32'd0, eps}) && (dsq4_reg != 64'd0);
            side5_reg.ax <= a4x_reg;
            side5_reg.sx <= s4x_reg;
            side5_reg.dy <= d4y_reg;
            side5_reg.az <= a4z_reg;
            side5_reg.sz <= s4z_reg;
            side5_reg.r <= r4_reg;
        end
    end

    assign out_valid = v_reg[4];
    assign dsq = dsq5_reg;
    assign side = side5_reg;

endmodule

// ----- hw/rtl/sbp_isqrt.sv -----
// Pipelined integer square root, one result bit per stage.
// Depends on sbp_pkg.
module sbp_isqrt (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [63:0]       x,
    input  sbp_pkg::sq_side_t in_side,
    output logic              out_valid,
    output logic [31:0]       root,
    output sbp_pkg::sq_side_t out_side
);
    import sbp_pkg::*;

    logic              v_reg    [SQRT_STEPS];
    logic [63:0]       x_reg    [SQRT_STEPS];
    logic [33:0]       rem_reg  [SQRT_STEPS];
    logic [31:0]       root_reg [SQRT_STEPS];
    sq_side_t          side_reg [SQRT_STEPS];

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
        logic        v_in;
        logic [63:0] x_in;
        logic [33:0] rem_in;
        logic [31:0] root_in;
        sq_side_t    side_in;
        logic [35:0] cur;
        logic [35:0] trial;

        if (g == 0) begin : g_first
            assign v_in = in_valid;
            assign x_in = x;
            assign rem_in = '0;
            assign root_in = '0;
            assign side_in = in_side;
        end else begin : g_rest
            assign v_in = v_reg[g-1];
            assign x_in = x_reg[g-1];
            assign rem_in = rem_reg[g-1];
            assign root_in = root_reg[g-1];
            assign side_in = side_reg[g-1];
        end

        assign cur = {rem_in, x_in[63:62]};
        assign trial = {2'b00, root_in, 2'b01};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g] <= 1'b0;
            end else if (en) begin
                v_reg[g] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[g] <= {x_in[61:0], 2'b00};
                side_reg[g] <= side_in;
                if (cur >= trial) begin
                    rem_reg[g] <= 34'(cur - trial);
                    root_reg[g] <= {root_in[30:0], 1'b1};
                end else begin
                    rem_reg[g] <= cur[33:0];
                    root_reg[g] <= {root_in[30:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = v_reg[SQRT_STEPS-1];
    assign root = root_reg[SQRT_STEPS-1];
    assign out_side = side_reg[SQRT_STEPS-1];

endmodule

// ----- hw/rtl/sbp_div.sv -----
// Two-lane pipelined restoring divider, one quotient bit per stage.
// The numerator must be below divisor * 2^31. Depends on sbp_pkg.
module sbp_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [61:0]       num_x,
    input  logic [61:0]       num_z,
    input  logic [30:0]       divisor,
    input  sbp_pkg::dv_side_t in_side,
    output logic              out_valid,
    output logic [30:0]       quot_x,
    output logic [30:0]       quot_z,
    output sbp_pkg::dv_side_t out_side
);
    import sbp_pkg::*;

    logic        v_reg   [DIV_STEPS];
    logic [30:0] nx_reg  [DIV_STEPS];
    logic [30:0] nz_reg  [DIV_STEPS];
    logic [30:0] rx_reg  [DIV_STEPS];
    logic [30:0] rz_reg  [DIV_STEPS];
    logic [30:0] qx_reg  [DIV_STEPS];
    logic [30:0] qz_reg  [DIV_STEPS];
    logic [30:0] dv_reg  [DIV_STEPS];
    dv_side_t    sd_reg  [DIV_STEPS];

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
        logic        v_in;
        logic [30:0] nx_in, nz_in, rx_in, rz_in, qx_in, qz_in, dv_in;
        dv_side_t    sd_in;
        logic [31:0] cx, cz;

        if (g == 0) begin : g_first
            assign v_in = in_valid;
            assign nx_in = num_x[30:0];
            assign nz_in = num_z[30:0];
            assign rx_in = num_x[61:31];
            assign rz_in = num_z[61:31];
            assign qx_in = '0;
            assign qz_in = '0;
            assign dv_in = divisor;
            assign sd_in = in_side;
        end else begin : g_rest
            assign v_in = v_reg[g-1];
            assign nx_in = nx_reg[g-1];
            assign nz_in = nz_reg[g-1];
            assign rx_in = rx_reg[g-1];
            assign rz_in = rz_reg[g-1];
            assign qx_in = qx_reg[g-1];
            assign qz_in = qz_reg[g-1];
            assign dv_in = dv_reg[g-1];
            assign sd_in = sd_reg[g-1];
        end

        assign cx = {rx_in, nx_in[30]};
        assign cz = {rz_in, nz_in[30]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g] <= 1'b0;
            end else if (en) begin
                v_reg[g] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                nx_reg[g] <= {nx_in[29:0], 1'b0};
                nz_reg[g] <= {nz_in[29:0], 1'b0};
                dv_reg[g] <= dv_in;
                sd_reg[g] <= sd_in;
                if (cx >= {1'b0, dv_in}) begin
                    rx_reg[g] <= 31'(cx - {1'b0, dv_in});
                    qx_reg[g] <= {qx_in[29:0], 1'b1};
                end else begin
                    rx_reg[g] <= cx[30:0];
                    qx_reg[g] <= {qx_in[29:0], 1'b0};
                end
                if (cz >= {1'b0, dv_in}) begin
                    rz_reg[g] <= 31'(cz - {1'b0, dv_in});
                    qz_reg[g] <= {qz_in[29:0], 1'b1};
                end else begin
                    rz_reg[g] <= cz[30:0];
                    qz_reg[g] <= {qz_in[29:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = v_reg[DIV_STEPS-1];
    assign quot_x = qx_reg[DIV_STEPS-1];
    assign quot_z = qz_reg[DIV_STEPS-1];
    assign out_side = sd_reg[DIV_STEPS-1];

endmodule

// ----- hw/rtl/sphere_box_pushout.sv -----
// Sphere against axis-aligned box push-out, fully pipelined.
// Input transfers pass in order through the front, square root, landing/multiply,
// divide and output register stages to the result. Throughput: one item per
// cycle; a stalled output freezes the whole pipeline in place.
// Reset (aresetn low, synchronous) clears all valid bits and loads the register defaults.
// Depends on sbp_pkg, sbp_front, sbp_isqrt and sbp_div.
module sphere_box_pushout (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // center_x, center_y, center_z, radius, box_min_x/y/z, box_max_x/y/z
    input  logic [319:0]                    s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // contact, landed, push_x, push_y, push_z
    output logic [103:0]                    m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sbp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_data
);
    import sbp_pkg::*;

    logic                en;
    logic [THRESH_W-1:0] thresh_reg;
    logic [EPS_W-1:0]    eps_reg;

    assign en = !m_tvalid || m_tready;
    assign s_tready = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= THRESH_RESET;
            eps_reg <= EPS_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_LANDING: thresh_reg <= cfg_data[THRESH_W-1:0];
                REG_EPSILON: eps_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic        f_valid;
    logic [63:0] f_dsq;
    sq_side_t    f_side;

    sbp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .cx        (s_tdata[31:0]),
        .cy        (s_tdata[63:32]),
        .cz        (s_tdata[95:64]),
        .radius    (s_tdata[126:96]),
        .lox       (s_tdata[158:127]),
        .loy       (s_tdata[190:159]),
        .loz       (s_tdata[222:191]),
        .hix       (s_tdata[254:223]),
        .hiy       (s_tdata[286:255]),
        .hiz       (s_tdata[318:287]),
        .eps       (eps_reg),
        .out_valid (f_valid),
        .dsq       (f_dsq),
        .side      (f_side)
    );

    logic        q_valid;
    logic [31:0] q_root;
    sq_side_t    q_side;

    sbp_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .x         (f_dsq),
        .in_side   (f_side),
        .out_valid (q_valid),
        .root      (q_root),
        .out_side  (q_side)
    );

    // Landing stage 1: penetration, threshold product and push numerators.
    logic               m1_valid_reg;
    logic [30:0]        m1_pen_reg, m1_dist_reg;
    logic [48:0]        m1_tprod_reg;
    logic [61:0]        m1_nx_reg, m1_nz_reg;
    sq_side_t           m1_side_reg;
    logic [30:0]        pen_next;

    assign pen_next = q_side.r - q_root[30:0];

    // Landing stage 2: landing decision.
    logic               m2_valid_reg;
    logic [30:0]        m2_dist_reg;
    logic [61:0]        m2_nx_reg, m2_nz_reg;
    dv_side_t           m2_side_reg;
    logic signed [49:0] lhs, rhs;

    assign lhs = 50'(m1_side_reg.dy) <<< 16;
    assign rhs = signed'({1'b0, m1_tprod_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
        end else if (en) begin
            m1_valid_reg <= q_valid;
            m2_valid_reg <= m1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_pen_reg <= pen_next;
            m1_dist_reg <= q_root[30:0];
            m1_tprod_reg <= thresh_reg * q_root;
            m1_nx_reg <= q_side.ax * pen_next;
            m1_nz_reg <= q_side.az * pen_next;
            m1_side_reg <= q_side;

            m2_dist_reg <= m1_dist_reg;
            m2_nx_reg <= m1_nx_reg;
            m2_nz_reg <= m1_nz_reg;
            m2_side_reg.contact <= m1_side_reg.contact;
            m2_side_reg.landed <= m1_side_reg.contact && (lhs > rhs);
            m2_side_reg.pen <= m1_pen_reg;
            m2_side_reg.sx <= m1_side_reg.sx;
            m2_side_reg.sz <= m1_side_reg.sz;
        end
    end

    logic        d_valid;
    logic [30:0] d_qx, d_qz;
    dv_side_t    d_side;

    sbp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (m2_valid_reg),
        .num_x     (m2_nx_reg),
        .num_z     (m2_nz_reg),
        .divisor   (m2_dist_reg),
        .in_side   (m2_side_reg),
        .out_valid (d_valid),
        .quot_x    (d_qx),
        .quot_z    (d_qz),
        .out_side  (d_side)
    );

    logic        out_valid_reg;
    logic [97:0] out_data_reg;
    logic        side_push;
    logic [31:0] px_next, pz_next, py_next;

    assign side_push = d_side.contact && !d_side.landed;
    assign px_next = !side_push ? 32'd0 : (d_side.sx ? 32'(-{1'b0, d_qx}) : {1'b0, d_qx});
    assign pz_next = !side_push ? 32'd0 : (d_side.sz ? 32'(-{1'b0, d_qz}) : {1'b0, d_qz});
    assign py_next = d_side.landed ? {1'b0, d_side.pen} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= {pz_next, py_next, px_next, d_side.landed, d_side.contact};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {6'd0, out_data_reg};

endmodule
